### src/ssa_pkg.sv
// Package for the sample slot allocator: field widths, operation and status
// codes, configuration register indexes and the controller state type.
// Depends on nothing; the core and the controller use it.
package ssa_pkg;

	localparam int SLOTS_DEF = 4096;
	localparam int SLOT_W    = 12;
	localparam int CAP_W     = 13;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(4096);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FRESH    = 3'd0,
		STATUS_REPLACED = 3'd1,
		STATUS_REUSED   = 3'd2,
		STATUS_NONE     = 3'd3,
		STATUS_FREED    = 3'd4,
		STATUS_REJECTED = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 1'b0,
		CFG_REPLACE  = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

endpackage

### src/sample_slot_allocator_core.sv
// Sample slot allocator: accepts allocate, free and clear commands.
// The result strobe done is registered and rises after the command has passed
// the EXEC state; no new command is taken while busy, as the registered read
// of the link memory must land before the pool state updates.
// Reset clears the pool and sets capacity 4096 with replacement enabled; the
// link memory is not cleared. The receiver cannot stall the result.
module sample_slot_allocator_core #(
	parameter int SLOTS = ssa_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ssa_pkg::OP_W-1:0]        operation,
	input  logic [ssa_pkg::SLOT_W-1:0]      slot_to_free,
	output logic                            done,
	output logic [ssa_pkg::STATUS_W-1:0]    status,
	output logic [ssa_pkg::SLOT_W-1:0]      slot_granted,
	input  logic                            cfg_write,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssa_pkg::CAP_W-1:0]       cfg_data
);

	localparam int SW = $clog2(SLOTS);

	logic          mem_we;
	logic [SW-1:0] mem_waddr;
	logic [SW:0]   mem_wdata;
	logic [SW-1:0] mem_raddr;
	logic [SW:0]   mem_rdata;

	ssa_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.slot_to_free (slot_to_free),
		.done         (done),
		.status       (status),
		.slot_granted (slot_granted),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	ssa_link_mem #(
		.SLOTS(SLOTS),
		.DW   (SW + 1)
	) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

### src/ssa_link_mem.sv
// Link memory of the free list: one entry per slot, holding the next link
// and an end-of-list mark. One write port and one registered read port.
// Depends on nothing outside this file.
module ssa_link_mem #(
	parameter int SLOTS = 4096,
	parameter int DW    = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(SLOTS)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(SLOTS)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [SLOTS];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/ssa_ctrl.sv
// Controller of the sample slot allocator: configuration registers, pool
// state, the two-state sequencer and the registered result.
// Depends on ssa_pkg; drives the link memory ports of ssa_link_mem.
module ssa_ctrl #(
	parameter int SLOTS = ssa_pkg::SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [ssa_pkg::OP_W-1:0]            operation,
	input  logic [ssa_pkg::SLOT_W-1:0]          slot_to_free,
	output logic                                done,
	output logic [ssa_pkg::STATUS_W-1:0]        status,
	output logic [ssa_pkg::SLOT_W-1:0]          slot_granted,
	input  logic                                cfg_write,
	input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssa_pkg::CAP_W-1:0]           cfg_data,
	output logic                                mem_we,
	output logic [$clog2(SLOTS)-1:0]            mem_waddr,
	output logic [$clog2(SLOTS):0]              mem_wdata,
	output logic [$clog2(SLOTS)-1:0]            mem_raddr,
	input  logic [$clog2(SLOTS):0]              mem_rdata
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	ssa_pkg::state_t state_q, state_d;

	logic [ssa_pkg::CAP_W-1:0]     capacity_q;
	logic                          replace_enable_q;
	logic [CW-1:0]                 used_count_q, used_count_d;
	logic [SW-1:0]                 replace_ptr_q, replace_ptr_d;
	logic [SW-1:0]                 free_head_q, free_head_d;
	logic                          free_empty_q, free_empty_d;

	logic [ssa_pkg::OP_W-1:0]      op_s1;
	logic [ssa_pkg::SLOT_W-1:0]    slot_s1;

	logic                          done_q;
	ssa_pkg::status_t              status_q, status_d;
	logic [ssa_pkg::SLOT_W-1:0]    granted_q, granted_d;

	logic [CW-1:0]                 cap;
	logic [SW-1:0]                 rp_id;
	logic [CW-1:0]                 rp_next;
	logic                          slot_ok;
	logic                          accept;

	assign accept = start && (state_q == ssa_pkg::ST_IDLE);
	assign busy   = (state_q == ssa_pkg::ST_EXEC);

	always_comb begin
		if (capacity_q == '0) begin
			cap = CW'(1);
		end else if (32'(capacity_q) > SLOTS) begin
			cap = CW'(SLOTS);
		end else begin
			cap = CW'(32'(capacity_q));
		end
	end

	assign rp_id   = (CW'(replace_ptr_q) < cap) ? replace_ptr_q : '0;
	assign rp_next = CW'(rp_id) + CW'(1);
	assign slot_ok = 32'(slot_s1) < 32'(cap);

	assign mem_raddr = free_head_q;
	assign mem_waddr = SW'(32'(slot_s1));
	assign mem_wdata = {free_empty_q, free_head_q};

	always_comb begin
		state_d       = state_q;
		used_count_d  = used_count_q;
		replace_ptr_d = replace_ptr_q;
		free_head_d   = free_head_q;
		free_empty_d  = free_empty_q;
		status_d      = ssa_pkg::STATUS_NONE;
		granted_d     = '0;
		mem_we        = 1'b0;
		case (state_q)
			ssa_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ssa_pkg::ST_EXEC;
				end
			end
			ssa_pkg::ST_EXEC: begin
				state_d = ssa_pkg::ST_IDLE;
				case (ssa_pkg::op_t'(op_s1))
					ssa_pkg::OP_ALLOC: begin
						if (used_count_q < cap) begin
							granted_d    = ssa_pkg::SLOT_W'(32'(used_count_q));
							used_count_d = used_count_q + CW'(1);
							status_d     = ssa_pkg::STATUS_FRESH;
						end else if (replace_enable_q) begin
							granted_d     = ssa_pkg::SLOT_W'(32'(rp_id));
							replace_ptr_d = (rp_next >= cap) ? '0 : SW'(32'(rp_next));
							status_d      = ssa_pkg::STATUS_REPLACED;
						end else if (!free_empty_q) begin
							granted_d    = ssa_pkg::SLOT_W'(32'(free_head_q));
							free_empty_d = mem_rdata[SW];
							free_head_d  = mem_rdata[SW-1:0];
							status_d     = ssa_pkg::STATUS_REUSED;
						end
					end
					ssa_pkg::OP_FREE: begin
						if (slot_ok) begin
							mem_we       = 1'b1;
							free_head_d  = SW'(32'(slot_s1));
							free_empty_d = 1'b0;
							status_d     = ssa_pkg::STATUS_FREED;
						end else begin
							status_d = ssa_pkg::STATUS_REJECTED;
						end
					end
					ssa_pkg::OP_CLEAR: begin
						used_count_d  = '0;
						replace_ptr_d = '0;
						free_head_d   = '0;
						free_empty_d  = 1'b1;
					end
					default: begin
						status_d = ssa_pkg::STATUS_NONE;
					end
				endcase
			end
			default: begin
				state_d = ssa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ssa_pkg::ST_IDLE;
			capacity_q       <= ssa_pkg::CAPACITY_RESET;
			replace_enable_q <= 1'b1;
			used_count_q     <= '0;
			replace_ptr_q    <= '0;
			free_head_q      <= '0;
			free_empty_q     <= 1'b1;
			done_q           <= 1'b0;
		end else begin
			state_q       <= state_d;
			used_count_q  <= used_count_d;
			replace_ptr_q <= replace_ptr_d;
			free_head_q   <= free_head_d;
			free_empty_q  <= free_empty_d;
			done_q        <= (state_q == ssa_pkg::ST_EXEC);
			if (cfg_write) begin
				case (ssa_pkg::cfg_idx_t'(cfg_index))
					ssa_pkg::CFG_CAPACITY: capacity_q <= cfg_data;
					ssa_pkg::CFG_REPLACE: replace_enable_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			slot_s1 <= slot_to_free;
		end
		if (state_q == ssa_pkg::ST_EXEC) begin
			status_q  <= status_d;
			granted_q <= granted_d;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign slot_granted = granted_q;

endmodule
